// ===== rtl/core/grm_pkg.sv =====
`default_nettype none

package grm_pkg;

	localparam int MAX_INDIVIDUALS = 64;
	localparam int MAX_MARKERS     = 1024;
	localparam int FRACTION_BITS   = 16;

	// register and field widths
	localparam int IC_W    = 7;
	localparam int MC_W    = 11;
	localparam int ROW_W   = $clog2(MAX_INDIVIDUALS);
	localparam int MARK_W  = $clog2(MAX_MARKERS);
	localparam int STORE_AW = ROW_W + MARK_W;
	localparam int STORE_DEPTH = MAX_INDIVIDUALS * MAX_MARKERS;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;
	localparam int RES_W   = 32;

	// datapath widths
	localparam int SUM_W   = $clog2(2 * MAX_INDIVIDUALS + 1);
	localparam int DIFF_W  = SUM_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int TERM_W  = 2 * SUM_W;
	localparam int NUM_W   = 2 * SUM_W + MARK_W;
	localparam int DEN_W   = 2 * SUM_W + MARK_W - 2;
	localparam int MAG_W   = NUM_W;
	localparam int DVD_W   = MAG_W + FRACTION_BITS;
	localparam int DCNT_W  = $clog2(DVD_W + 1);

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_ZERO_DEN = 2'd1,
		STS_BAD      = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_DISPATCH,
		OP_LOAD_RD,
		OP_LOAD_WR,
		OP_READ_INIT,
		OP_WALK,
		OP_NOP,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_ROUND,
		OP_EMIT
	} uop_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_ITEM,
		C_IS_READ,
		C_LOAD_SKIP,
		C_READ_BAD,
		C_MORE_K,
		C_DEN_ZERO,
		C_DIV_BUSY,
		C_OUT_BUSY
	} cond_t;

	typedef logic [3:0] step_t;

	localparam step_t PC_IDLE     = 4'd0;
	localparam step_t PC_DISPATCH = 4'd1;
	localparam step_t PC_LOAD_RD  = 4'd2;
	localparam step_t PC_LOAD_WR  = 4'd3;
	localparam step_t PC_READ     = 4'd4;
	localparam step_t PC_WALK     = 4'd5;
	localparam step_t PC_DRAIN0   = 4'd6;
	localparam step_t PC_DRAIN1   = 4'd7;
	localparam step_t PC_DIV_INIT = 4'd8;
	localparam step_t PC_DIV      = 4'd9;
	localparam step_t PC_ROUND    = 4'd10;
	localparam step_t PC_EMIT     = 4'd11;
	localparam step_t PC_RETURN   = 4'd12;

	typedef struct packed {
		uop_t  op;
		cond_t cond;
		step_t target;
	} ucode_t;

	typedef struct packed {
		logic no_item;
		logic is_read;
		logic load_skip;
		logic read_bad;
		logic more_k;
		logic den_zero;
		logic div_busy;
		logic out_busy;
	} flags_t;

	// control store: next step is target when the condition holds, else pc + 1
	function automatic ucode_t ucode_rom(step_t pc);
		ucode_t w;
		unique case (pc)
			PC_IDLE:     w = '{OP_IDLE,      C_NO_ITEM,   PC_IDLE};
			PC_DISPATCH: w = '{OP_DISPATCH,  C_IS_READ,   PC_READ};
			PC_LOAD_RD:  w = '{OP_LOAD_RD,   C_LOAD_SKIP, PC_IDLE};
			PC_LOAD_WR:  w = '{OP_LOAD_WR,   C_ALWAYS,    PC_IDLE};
			PC_READ:     w = '{OP_READ_INIT, C_READ_BAD,  PC_EMIT};
			PC_WALK:     w = '{OP_WALK,      C_MORE_K,    PC_WALK};
			PC_DRAIN0:   w = '{OP_NOP,       C_NEVER,     PC_IDLE};
			PC_DRAIN1:   w = '{OP_NOP,       C_NEVER,     PC_IDLE};
			PC_DIV_INIT: w = '{OP_DIV_INIT,  C_DEN_ZERO,  PC_EMIT};
			PC_DIV:      w = '{OP_DIV_STEP,  C_DIV_BUSY,  PC_DIV};
			PC_ROUND:    w = '{OP_ROUND,     C_NEVER,     PC_IDLE};
			PC_EMIT:     w = '{OP_EMIT,      C_OUT_BUSY,  PC_EMIT};
			PC_RETURN:   w = '{OP_NOP,       C_ALWAYS,    PC_IDLE};
			default:     w = '{OP_NOP,       C_ALWAYS,    PC_IDLE};
		endcase
		return w;
	endfunction

	// genotype code to allele count; -2 counts as -1
	function automatic logic [1:0] allele_of(logic [1:0] code);
		logic [1:0] a;
		case (code)
			2'b00:   a = 2'd1;
			2'b01:   a = 2'd2;
			default: a = 2'd0;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/grm_seq.sv =====
`default_nettype none

module grm_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire grm_pkg::flags_t flags,
	output grm_pkg::uop_t        op
);

	grm_pkg::step_t  pc_q;
	grm_pkg::ucode_t uw;
	logic            take;

	assign uw = grm_pkg::ucode_rom(pc_q);
	assign op = uw.op;

	always_comb begin
		unique case (uw.cond)
			grm_pkg::C_NEVER:     take = 1'b0;
			grm_pkg::C_ALWAYS:    take = 1'b1;
			grm_pkg::C_NO_ITEM:   take = flags.no_item;
			grm_pkg::C_IS_READ:   take = flags.is_read;
			grm_pkg::C_LOAD_SKIP: take = flags.load_skip;
			grm_pkg::C_READ_BAD:  take = flags.read_bad;
			grm_pkg::C_MORE_K:    take = flags.more_k;
			grm_pkg::C_DEN_ZERO:  take = flags.den_zero;
			grm_pkg::C_DIV_BUSY:  take = flags.div_busy;
			grm_pkg::C_OUT_BUSY:  take = flags.out_busy;
			default:              take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= grm_pkg::PC_IDLE;
		end else if (take) begin
			pc_q <= uw.target;
		end else begin
			pc_q <= pc_q + 4'd1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/grm_mac.sv =====
`default_nettype none

module grm_mac (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire grm_pkg::uop_t                           op,
	input  wire logic                                    cfg_clear,
	input  wire logic [grm_pkg::IC_W-1:0]                n,
	input  wire logic [grm_pkg::MC_W-1:0]                m,
	input  wire logic                                    is_read,
	input  wire logic                                    starts_over,
	input  wire logic [1:0]                              genotype,
	input  wire logic [grm_pkg::ROW_W-1:0]               first_row,
	input  wire logic [grm_pkg::ROW_W-1:0]               second_row,
	output logic                                         load_skip,
	output logic                                         read_bad,
	output logic                                         more_k,
	output logic                                         den_zero,
	output logic signed [grm_pkg::NUM_W-1:0]             num_acc,
	output logic [grm_pkg::DEN_W-1:0]                    den_acc
);

	logic [1:0]                    geno_mem [grm_pkg::STORE_DEPTH];
	logic [grm_pkg::SUM_W-1:0]     sum_mem  [grm_pkg::MAX_MARKERS];

	logic [grm_pkg::STORE_AW-1:0]  load_pos_q;
	logic [grm_pkg::MARK_W-1:0]    load_k_q;
	logic [grm_pkg::ROW_W-1:0]     load_row_q;
	logic                          load_done_q;

	logic [grm_pkg::STORE_AW-1:0]  addr_i_q, addr_j_q;
	logic [grm_pkg::MARK_W-1:0]    walk_k_q;

	logic [1:0]                    gi_s1, gj_s1;
	logic [grm_pkg::SUM_W-1:0]     sum_rd_s1;
	logic                          v_s1;
	logic signed [grm_pkg::PROD_W-1:0] prod_s2;
	logic [grm_pkg::TERM_W-1:0]    term_s2;
	logic                          v_s2;

	logic signed [grm_pkg::NUM_W-1:0] num_acc_q;
	logic [grm_pkg::DEN_W-1:0]     den_acc_q;

	logic                          cfg_ok;
	logic [grm_pkg::MC_W-1:0]      m_last;
	logic                          load_last_k, load_last_row;
	logic [1:0]                    allele;
	logic [grm_pkg::MARK_W-1:0]    sum_raddr;
	logic [grm_pkg::ROW_W+grm_pkg::MC_W-1:0] base_i, base_j;
	logic [grm_pkg::SUM_W-1:0]     n_x2, na_i, na_j;
	logic signed [grm_pkg::DIFF_W-1:0] di, dj;

	assign cfg_ok = (n != '0) && (n <= grm_pkg::IC_W'(grm_pkg::MAX_INDIVIDUALS))
		&& (m != '0) && (m <= grm_pkg::MC_W'(grm_pkg::MAX_MARKERS));
	assign m_last        = m - grm_pkg::MC_W'(1);
	assign load_last_k   = {1'b0, load_k_q} == m_last;
	assign load_last_row = {1'b0, load_row_q} == n - grm_pkg::IC_W'(1);
	assign allele        = grm_pkg::allele_of(genotype);

	assign load_skip = !cfg_ok || load_done_q;
	assign read_bad  = !cfg_ok || !load_done_q || ({1'b0, first_row} >= n)
		|| ({1'b0, second_row} >= n);
	assign more_k    = {1'b0, walk_k_q} != m_last;
	assign den_zero  = den_acc_q == '0;
	assign num_acc   = num_acc_q;
	assign den_acc   = den_acc_q;

	assign base_i = (grm_pkg::ROW_W+grm_pkg::MC_W)'(first_row)
		* (grm_pkg::ROW_W+grm_pkg::MC_W)'(m);
	assign base_j = (grm_pkg::ROW_W+grm_pkg::MC_W)'(second_row)
		* (grm_pkg::ROW_W+grm_pkg::MC_W)'(m);

	// load sequencing; the first row overwrites the sums, so no clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q  <= '0;
			load_k_q    <= '0;
			load_row_q  <= '0;
			load_done_q <= 1'b0;
		end else if (cfg_clear) begin
			load_pos_q  <= '0;
			load_k_q    <= '0;
			load_row_q  <= '0;
			load_done_q <= 1'b0;
		end else if (op == grm_pkg::OP_DISPATCH && !is_read && starts_over && cfg_ok) begin
			load_pos_q  <= '0;
			load_k_q    <= '0;
			load_row_q  <= '0;
			load_done_q <= 1'b0;
		end else if (op == grm_pkg::OP_LOAD_WR) begin
			load_pos_q <= load_pos_q + grm_pkg::STORE_AW'(1);
			if (load_last_k) begin
				load_k_q   <= '0;
				load_row_q <= load_row_q + grm_pkg::ROW_W'(1);
				if (load_last_row) begin
					load_done_q <= 1'b1;
				end
			end else begin
				load_k_q <= load_k_q + grm_pkg::MARK_W'(1);
			end
		end
	end

	assign sum_raddr = (op == grm_pkg::OP_WALK) ? walk_k_q : load_k_q;

	always_ff @(posedge clk) begin
		if (op == grm_pkg::OP_LOAD_WR) begin
			geno_mem[load_pos_q] <= allele;
			if (load_row_q == '0) begin
				sum_mem[load_k_q] <= grm_pkg::SUM_W'(allele);
			end else begin
				sum_mem[load_k_q] <= sum_rd_s1 + grm_pkg::SUM_W'(allele);
			end
		end
		sum_rd_s1 <= sum_mem[sum_raddr];
		gi_s1     <= geno_mem[addr_i_q];
		gj_s1     <= geno_mem[addr_j_q];
	end

	// marker walk addresses
	always_ff @(posedge clk) begin
		if (op == grm_pkg::OP_READ_INIT) begin
			addr_i_q <= base_i[grm_pkg::STORE_AW-1:0];
			addr_j_q <= base_j[grm_pkg::STORE_AW-1:0];
			walk_k_q <= '0;
		end else if (op == grm_pkg::OP_WALK) begin
			addr_i_q <= addr_i_q + grm_pkg::STORE_AW'(1);
			addr_j_q <= addr_j_q + grm_pkg::STORE_AW'(1);
			walk_k_q <= walk_k_q + grm_pkg::MARK_W'(1);
		end
	end

	assign n_x2 = {n, 1'b0};

	always_comb begin
		case (gi_s1)
			2'd1:    na_i = grm_pkg::SUM_W'(n);
			2'd2:    na_i = n_x2;
			default: na_i = '0;
		endcase
		case (gj_s1)
			2'd1:    na_j = grm_pkg::SUM_W'(n);
			2'd2:    na_j = n_x2;
			default: na_j = '0;
		endcase
		di = $signed({1'b0, na_i}) - $signed({1'b0, sum_rd_s1});
		dj = $signed({1'b0, na_j}) - $signed({1'b0, sum_rd_s1});
	end

	always_ff @(posedge clk) begin
		prod_s2 <= grm_pkg::PROD_W'(di) * grm_pkg::PROD_W'(dj);
		term_s2 <= grm_pkg::TERM_W'(sum_rd_s1) * grm_pkg::TERM_W'(n_x2 - sum_rd_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			num_acc_q <= '0;
			den_acc_q <= '0;
		end else begin
			v_s1 <= op == grm_pkg::OP_WALK;
			v_s2 <= v_s1;
			if (op == grm_pkg::OP_READ_INIT) begin
				num_acc_q <= '0;
				den_acc_q <= '0;
			end else if (v_s2) begin
				num_acc_q <= num_acc_q + grm_pkg::NUM_W'(prod_s2);
				den_acc_q <= den_acc_q + grm_pkg::DEN_W'(term_s2);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/grm_div.sv =====
`default_nettype none

module grm_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire grm_pkg::uop_t                   op,
	input  wire logic signed [grm_pkg::NUM_W-1:0] num_acc,
	input  wire logic [grm_pkg::DEN_W-1:0]       den_acc,
	output logic                                 div_busy,
	output logic [grm_pkg::RES_W-1:0]            result,
	output grm_pkg::status_t                     sts
);

	localparam logic [grm_pkg::RES_W-1:0] POS_MAX = {1'b0, {(grm_pkg::RES_W-1){1'b1}}};
	localparam logic [grm_pkg::RES_W-1:0] NEG_MAX = {1'b1, {(grm_pkg::RES_W-1){1'b0}}};

	logic [grm_pkg::DVD_W-1:0]  dq_q;
	logic [grm_pkg::DEN_W-1:0]  rem_q;
	logic [grm_pkg::DCNT_W-1:0] cnt_q;
	logic                       neg_q;
	logic [grm_pkg::RES_W-1:0]  res_q;
	grm_pkg::status_t           sts_q;

	logic signed [grm_pkg::NUM_W:0] num2;
	logic [grm_pkg::NUM_W:0]        mag_full;
	logic [grm_pkg::DEN_W:0]        trial, diff;
	logic                           qbit, up, sat;
	logic [grm_pkg::RES_W-1:0]      mag32, rounded;

	assign num2     = {num_acc, 1'b0};
	assign mag_full = num2[grm_pkg::NUM_W] ? -num2 : num2;

	// restoring division, one quotient bit per step
	assign trial = {rem_q, dq_q[grm_pkg::DVD_W-1]};
	assign diff  = trial - {1'b0, den_acc};
	assign qbit  = !diff[grm_pkg::DEN_W];

	assign div_busy = cnt_q != grm_pkg::DCNT_W'(1);

	assign up    = {rem_q, 1'b0} >= {1'b0, den_acc};
	assign sat   = |dq_q[grm_pkg::DVD_W-1:grm_pkg::RES_W-1];
	assign mag32 = {1'b0, dq_q[grm_pkg::RES_W-2:0]} + grm_pkg::RES_W'(up);

	always_comb begin
		if (sat) begin
			rounded = neg_q ? NEG_MAX : POS_MAX;
		end else if (neg_q) begin
			rounded = mag32[grm_pkg::RES_W-1] ? NEG_MAX : -mag32;
		end else begin
			rounded = mag32[grm_pkg::RES_W-1] ? POS_MAX : mag32;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sts_q <= grm_pkg::STS_OK;
			res_q <= '0;
		end else begin
			case (op)
				grm_pkg::OP_READ_INIT: begin
					sts_q <= grm_pkg::STS_BAD;
					res_q <= '0;
				end
				grm_pkg::OP_DIV_INIT: begin
					sts_q <= grm_pkg::STS_ZERO_DEN;
					res_q <= '0;
					cnt_q <= grm_pkg::DCNT_W'(grm_pkg::DVD_W);
				end
				grm_pkg::OP_DIV_STEP: begin
					cnt_q <= cnt_q - grm_pkg::DCNT_W'(1);
				end
				grm_pkg::OP_ROUND: begin
					sts_q <= grm_pkg::STS_OK;
					res_q <= rounded;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (op == grm_pkg::OP_DIV_INIT) begin
			neg_q <= num2[grm_pkg::NUM_W];
			dq_q  <= {mag_full[grm_pkg::MAG_W-1:0], {grm_pkg::FRACTION_BITS{1'b0}}};
			rem_q <= '0;
		end else if (op == grm_pkg::OP_DIV_STEP) begin
			dq_q  <= {dq_q[grm_pkg::DVD_W-2:0], qbit};
			rem_q <= qbit ? diff[grm_pkg::DEN_W-1:0] : trial[grm_pkg::DEN_W-1:0];
		end
	end

	assign result = res_q;
	assign sts    = sts_q;

endmodule

`default_nettype wire

// ===== rtl/core/genomic_relationship_matrix.sv =====
// channel   direction  handshake                  payload
// item      in         item_valid / item_stall    kind, starts_over, genotype,
//                                                 first_individual, second_individual
// result    out        result_valid / result_stall relationship, status
// apb       in/out     psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// A load steps through accept, dispatch, sum read and store (store skipped when full).
// A read walks one marker per cycle through the genotype and allele-sum memories,
// then a 42-step bit-serial divider; bad reads and zero denominators skip ahead.
// No clearing pass after reset: the first row of each load overwrites the sums.
// A result waiting in the output register holds the sequencer only when the
// next read is ready to deliver; loads go on meanwhile.
`default_nettype none

module genomic_relationship_matrix (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic                          kind,
	input  wire logic                          starts_over,
	input  wire logic signed [1:0]             genotype,
	input  wire logic [5:0]                    first_individual,
	input  wire logic [5:0]                    second_individual,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic signed [31:0]                 relationship,
	output logic [1:0]                         status,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [grm_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [grm_pkg::DATA_W-1:0]    pwdata,
	output logic [grm_pkg::DATA_W-1:0]         prdata,
	output logic                               pready
);

	logic [grm_pkg::IC_W-1:0]  n_q;
	logic [grm_pkg::MC_W-1:0]  m_q;
	logic                      cfg_wr;

	logic                      kind_q, starts_over_q;
	logic [1:0]                genotype_q;
	logic [grm_pkg::ROW_W-1:0] first_q, second_q;

	logic                      result_valid_q;
	logic [grm_pkg::RES_W-1:0] relationship_q;
	logic [1:0]                status_q;

	grm_pkg::uop_t             op;
	grm_pkg::flags_t           flags;
	logic                      accept, out_busy;
	logic                      load_skip, read_bad, more_k, den_zero, div_busy;
	logic signed [grm_pkg::NUM_W-1:0] num_acc;
	logic [grm_pkg::DEN_W-1:0] den_acc;
	logic [grm_pkg::RES_W-1:0] div_result;
	grm_pkg::status_t          div_sts;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = paddr[2] ? grm_pkg::DATA_W'(m_q) : grm_pkg::DATA_W'(n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= grm_pkg::IC_W'(grm_pkg::MAX_INDIVIDUALS);
			m_q <= grm_pkg::MC_W'(grm_pkg::MAX_MARKERS);
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				m_q <= pwdata[grm_pkg::MC_W-1:0];
			end else begin
				n_q <= pwdata[grm_pkg::IC_W-1:0];
			end
		end
	end

	// input transfer
	assign item_stall = op != grm_pkg::OP_IDLE;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q        <= kind;
			starts_over_q <= starts_over;
			genotype_q    <= genotype;
			first_q       <= first_individual;
			second_q      <= second_individual;
		end
	end

	// output register
	assign out_busy = result_valid_q && result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (op == grm_pkg::OP_EMIT && !out_busy) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == grm_pkg::OP_EMIT && !out_busy) begin
			relationship_q <= div_result;
			status_q       <= div_sts;
		end
	end

	assign result_valid = result_valid_q;
	assign relationship = relationship_q;
	assign status       = status_q;

	always_comb begin
		flags.no_item   = !item_valid;
		flags.is_read   = kind_q;
		flags.load_skip = load_skip;
		flags.read_bad  = read_bad;
		flags.more_k    = more_k;
		flags.den_zero  = den_zero;
		flags.div_busy  = div_busy;
		flags.out_busy  = out_busy;
	end

	grm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.op     (op)
	);

	grm_mac u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.cfg_clear   (cfg_wr),
		.n           (n_q),
		.m           (m_q),
		.is_read     (kind_q),
		.starts_over (starts_over_q),
		.genotype    (genotype_q),
		.first_row   (first_q),
		.second_row  (second_q),
		.load_skip   (load_skip),
		.read_bad    (read_bad),
		.more_k      (more_k),
		.den_zero    (den_zero),
		.num_acc     (num_acc),
		.den_acc     (den_acc)
	);

	grm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.num_acc  (num_acc),
		.den_acc  (den_acc),
		.div_busy (div_busy),
		.result   (div_result),
		.sts      (div_sts)
	);

endmodule

`default_nettype wire

// ===== rtl/core/grm_chk.sv =====
`default_nettype none

module grm_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_valid,
	input wire logic        item_stall,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [31:0] relationship,
	input wire logic [1:0]  status
);

	// a held result does not change
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(relationship)
			&& $stable(status))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> status != 2'd3)
		else $error("undefined status code");

	// flagged results carry a zero entry
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != 2'd0 |-> relationship == 32'd0)
		else $error("non-zero entry on flagged result");

	// every transfer keeps the block busy for at least the next cycle
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item taken on consecutive cycles");

endmodule

bind genomic_relationship_matrix grm_chk u_chk (.*);

`default_nettype wire

// ===== tb/tb_genomic_relationship_matrix.sv =====
module tb_genomic_relationship_matrix;

	localparam int CLK_PERIOD   = 20;
	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int SETTLE       = 64;
	localparam int END_WAIT     = 1200;
	localparam int HOLD_LEN     = 500;
	localparam int RANDOM_ITEMS = 190;

	localparam int REG_INDIVIDUALS = 0;
	localparam int REG_MARKERS     = 1;

	localparam bit KIND_LOAD = 1'b0;
	localparam bit KIND_READ = 1'b1;

	localparam logic [1:0] GT_ZERO   = 2'b00;
	localparam logic [1:0] GT_PLUS   = 2'b01;
	localparam logic [1:0] GT_MINUS2 = 2'b10;
	localparam logic [1:0] GT_MINUS  = 2'b11;

	localparam int IDLE_NONE     = 0;
	localparam int IDLE_SENDER   = 1;
	localparam int IDLE_RECEIVER = 2;
	localparam int IDLE_BOTH     = 3;

	typedef struct {
		logic [31:0]       rel;
		grm_pkg::status_t  sts;
	} entry_t;

	typedef struct {
		bit                cfg_row;
		int                cfg_n;
		int                cfg_m;
		bit                kind;
		bit                restart;
		logic [1:0]        code;
		logic [5:0]        fi;
		logic [5:0]        si;
		bit                pinned;
		logic [31:0]       pin_rel;
		grm_pkg::status_t  pin_sts;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic kind = KIND_LOAD;
	logic starts_over = 1'b0;
	logic signed [1:0] genotype = '0;
	logic [5:0] first_individual = '0;
	logic [5:0] second_individual = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [31:0] relationship;
	logic [1:0] status;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [grm_pkg::ADDR_W-1:0] paddr = '0;
	logic [grm_pkg::DATA_W-1:0] pwdata = '0;
	logic [grm_pkg::DATA_W-1:0] prdata;
	logic pready;

	// shadow of a typed-in expectation, travels with the item payload
	bit               pin_on = 1'b0;
	logic [31:0]      pin_rel = '0;
	grm_pkg::status_t pin_sts = grm_pkg::STS_OK;

	int send_pct = 0;
	int stall_pct = 0;
	bit hold_tog = 1'b0;
	int faults = 0;
	int offered = 0;

	// predictor state
	bit [1:0]    allele_mem [grm_pkg::STORE_DEPTH];
	int unsigned allele_tot [grm_pkg::MAX_MARKERS];
	int unsigned fill_pos;
	bit          set_full;
	int unsigned rows_cfg;
	int unsigned cols_cfg;

	entry_t due_entries [$];

	genomic_relationship_matrix uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.kind(kind),
		.starts_over(starts_over),
		.genotype(genotype),
		.first_individual(first_individual),
		.second_individual(second_individual),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.relationship(relationship),
		.status(status),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("end of test: mismatches");
		$finish;
	end

	function automatic void flag_fault(string what);
		faults++;
		if (faults <= 10) begin
			$display("%0t: %s", $time, what);
		end
	endfunction

	function automatic void clear_set();
		foreach (allele_tot[k]) begin
			allele_tot[k] = 0;
		end
		fill_pos = 0;
		set_full = 1'b0;
	endfunction

	function automatic bit cfg_valid();
		return rows_cfg >= 1 && rows_cfg <= grm_pkg::MAX_INDIVIDUALS
			&& cols_cfg >= 1 && cols_cfg <= grm_pkg::MAX_MARKERS;
	endfunction

	function automatic void reset_model();
		foreach (allele_mem[p]) begin
			allele_mem[p] = 2'd0;
		end
		clear_set();
		rows_cfg = grm_pkg::MAX_INDIVIDUALS;
		cols_cfg = grm_pkg::MAX_MARKERS;
	endfunction

	function automatic void write_model_reg(int idx, int value);
		if (idx == REG_INDIVIDUALS) begin
			rows_cfg = value & 'h7F;
			clear_set();
		end else if (idx == REG_MARKERS) begin
			cols_cfg = value & 'h7FF;
			clear_set();
		end
	endfunction

	function automatic void store_genotype(bit restart, logic [1:0] code);
		int unsigned total;
		bit [1:0] a;
		if (!cfg_valid()) begin
			return;
		end
		if (restart) begin
			clear_set();
		end
		total = rows_cfg * cols_cfg;
		if (set_full || fill_pos >= total) begin
			return;
		end
		case (code)
			GT_ZERO: a = 2'd1;
			GT_PLUS: a = 2'd2;
			default: a = 2'd0;
		endcase
		allele_mem[fill_pos] = a;
		allele_tot[fill_pos % cols_cfg] += a;
		fill_pos++;
		if (fill_pos >= total) begin
			set_full = 1'b1;
		end
	endfunction

	// 2 * sum (n*a_i - s)(n*a_j - s) / sum s*(2n - s), rounded half away from zero
	function automatic entry_t relationship_of(logic [5:0] fi, logic [5:0] si);
		entry_t e;
		longint n, s, di, dj, num, den;
		longint unsigned mag, q, r, ud, frac;
		bit neg;
		int unsigned k;
		e.rel = '0;
		if (!cfg_valid() || !set_full || fi >= rows_cfg || si >= rows_cfg) begin
			e.sts = grm_pkg::STS_BAD;
			return e;
		end
		n = rows_cfg;
		num = 0;
		den = 0;
		for (k = 0; k < cols_cfg; k++) begin
			s = allele_tot[k];
			di = n * longint'(allele_mem[fi * cols_cfg + k]) - s;
			dj = n * longint'(allele_mem[si * cols_cfg + k]) - s;
			num += di * dj;
			den += s * (2 * n - s);
		end
		num *= 2;
		if (den <= 0) begin
			e.sts = grm_pkg::STS_ZERO_DEN;
			return e;
		end
		neg = num < 0;
		mag = neg ? -num : num;
		ud = den;
		q = mag / ud;
		r = mag % ud;
		if (q >= (64'd1 << (31 - grm_pkg::FRACTION_BITS))) begin
			e.rel = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			frac = (2 * (r << grm_pkg::FRACTION_BITS) + ud) / (2 * ud);
			mag = (q << grm_pkg::FRACTION_BITS) + frac;
			if (neg) begin
				e.rel = (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
			end else begin
				e.rel = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
			end
		end
		e.sts = grm_pkg::STS_OK;
		return e;
	endfunction

	function automatic row_t load_row(bit restart, logic [1:0] code);
		row_t r;
		r.cfg_row = 1'b0;
		r.cfg_n = 0;
		r.cfg_m = 0;
		r.kind = KIND_LOAD;
		r.restart = restart;
		r.code = code;
		r.fi = 6'($urandom);
		r.si = 6'($urandom);
		r.pinned = 1'b0;
		r.pin_rel = '0;
		r.pin_sts = grm_pkg::STS_OK;
		return r;
	endfunction

	function automatic row_t read_row(logic [5:0] fi, logic [5:0] si);
		row_t r;
		r = load_row(1'($urandom), 2'($urandom));
		r.kind = KIND_READ;
		r.fi = fi;
		r.si = si;
		return r;
	endfunction

	function automatic row_t read_row_fixed(logic [5:0] fi, logic [5:0] si,
		grm_pkg::status_t sts);
		row_t r;
		r = read_row(fi, si);
		r.pinned = 1'b1;
		r.pin_sts = sts;
		return r;
	endfunction

	// receiver: random stall, or a long hold-off counted here once requested
	always @(posedge clk) begin : receiver
		bit hold_seen;
		int hold_left;
		if (hold_tog != hold_seen) begin
			hold_seen = hold_tog;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : watch
		entry_t e;
		if (item_valid && !item_stall) begin
			if (kind == KIND_READ) begin
				e = relationship_of(first_individual, second_individual);
				if (pin_on) begin
					e.rel = pin_rel;
					e.sts = pin_sts;
				end
				due_entries.push_back(e);
			end else begin
				store_genotype(starts_over, genotype);
			end
		end
		if (result_valid && !result_stall) begin
			if (due_entries.size() == 0) begin
				flag_fault($sformatf("unexpected transfer: relationship %h status %0d",
					relationship, status));
			end else begin
				e = due_entries.pop_front();
				if (relationship !== e.rel || status !== e.sts) begin
					flag_fault($sformatf({"entry mismatch: relationship %h status %0d, ",
						"wanted %h status %0d"}, relationship, status, e.rel, e.sts));
				end
			end
		end
	end

	task automatic set_idle(int mode);
		case (mode)
			IDLE_SENDER: begin
				send_pct = 78;
				stall_pct <= 0;
			end
			IDLE_RECEIVER: begin
				send_pct = 0;
				stall_pct <= 78;
			end
			IDLE_BOTH: begin
				send_pct = 13;
				stall_pct <= 13;
			end
			default: begin
				send_pct = 0;
				stall_pct <= 0;
			end
		endcase
	endtask

	task automatic offer(row_t r);
		if (send_pct != 0 && $urandom_range(99) < send_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_pct);
		end
		item_valid <= 1'b1;
		kind <= r.kind;
		starts_over <= r.restart;
		genotype <= r.code;
		first_individual <= r.fi;
		second_individual <= r.si;
		pin_on <= r.pinned;
		pin_rel <= r.pin_rel;
		pin_sts <= r.pin_sts;
		do @(posedge clk); while (item_stall);
		offered++;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (due_entries.size() != 0) @(posedge clk);
	endtask

	task automatic reg_write(int idx, int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= grm_pkg::ADDR_W'(idx << 2);
		pwdata <= grm_pkg::DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		write_model_reg(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_read(int idx, output logic [grm_pkg::DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= grm_pkg::ADDR_W'(idx << 2);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// only once the block has gone quiet: loads leave nothing to wait on
	task automatic set_config(int n, int m);
		logic [grm_pkg::DATA_W-1:0] got;
		logic [grm_pkg::DATA_W-1:0] want;
		drain();
		repeat (SETTLE) @(posedge clk);
		reg_write(REG_INDIVIDUALS, n);
		reg_write(REG_MARKERS, m);
		for (int idx = REG_INDIVIDUALS; idx <= REG_MARKERS; idx++) begin
			reg_read(idx, got);
			want = (idx == REG_INDIVIDUALS) ? (n & 'h7F) : (m & 'h7FF);
			if (got !== want) begin
				flag_fault($sformatf("register %0d reads %h, wanted %h", idx, got, want));
			end
		end
	endtask

	// one genotype set: well-formed loads with the odd stray read or restart,
	// then queries, mostly in range, with the odd extra load
	task automatic run_set(int n, int m, int nreads, int mode);
		int total, p;
		bit bad, restarted;
		logic [5:0] fi, si;
		set_config(n, m);
		set_idle(mode);
		bad = n < 1 || n > grm_pkg::MAX_INDIVIDUALS || m < 1 || m > grm_pkg::MAX_MARKERS;
		total = bad ? 2 : n * m;
		p = 0;
		restarted = 1'b0;
		while (p < total) begin
			if ($urandom_range(99) < 4) begin
				offer(read_row(6'($urandom), 6'($urandom)));
			end
			if (!restarted && p > 0 && $urandom_range(99) < 2) begin
				restarted = 1'b1;
				offer(load_row(1'b1, 2'($urandom)));
				p = 1;
			end else begin
				offer(load_row((p == 0) ? 1'($urandom) : 1'b0, 2'($urandom)));
				p++;
			end
		end
		repeat (nreads) begin
			fi = (bad || $urandom_range(99) < 15) ? 6'($urandom) : 6'($urandom_range(n - 1));
			si = (bad || $urandom_range(99) < 15) ? 6'($urandom) : 6'($urandom_range(n - 1));
			offer(read_row(fi, si));
			if ($urandom_range(99) < 5) begin
				offer(load_row(1'b0, 2'($urandom)));
			end
		end
	endtask

	initial begin
		row_t steps [$];
		row_t r;
		int base, sel, n, m, set_no;

		reset_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset state, partial and complete sets, bad rows, monomorphic set
		steps.push_back(read_row_fixed(0, 0, grm_pkg::STS_BAD));
		steps.push_back(read_row_fixed(63, 63, grm_pkg::STS_BAD));
		r = read_row(0, 0);
		r.cfg_row = 1'b1;
		r.cfg_n = 3;
		r.cfg_m = 2;
		steps.push_back(r);
		steps.push_back(read_row_fixed(0, 1, grm_pkg::STS_BAD));
		steps.push_back(load_row(1'b1, GT_MINUS));
		steps.push_back(load_row(1'b0, GT_ZERO));
		steps.push_back(load_row(1'b0, GT_PLUS));
		steps.push_back(load_row(1'b0, GT_MINUS2));
		steps.push_back(read_row_fixed(0, 0, grm_pkg::STS_BAD));
		steps.push_back(load_row(1'b0, GT_PLUS));
		steps.push_back(load_row(1'b0, GT_MINUS));
		steps.push_back(load_row(1'b0, GT_PLUS));
		steps.push_back(read_row(0, 0));
		steps.push_back(read_row(0, 2));
		steps.push_back(read_row(2, 1));
		steps.push_back(read_row_fixed(3, 0, grm_pkg::STS_BAD));
		steps.push_back(read_row_fixed(0, 63, grm_pkg::STS_BAD));
		steps.push_back(load_row(1'b1, GT_PLUS));
		steps.push_back(read_row_fixed(1, 1, grm_pkg::STS_BAD));
		repeat (5) steps.push_back(load_row(1'b0, GT_PLUS));
		steps.push_back(read_row_fixed(0, 1, grm_pkg::STS_ZERO_DEN));
		steps.push_back(read_row_fixed(2, 2, grm_pkg::STS_ZERO_DEN));
		foreach (steps[i]) begin
			if (steps[i].cfg_row) begin
				set_config(steps[i].cfg_n, steps[i].cfg_m);
			end else begin
				offer(steps[i]);
			end
		end

		// register extremes and out-of-range settings
		run_set(grm_pkg::MAX_INDIVIDUALS, 1, 10, IDLE_SENDER);
		run_set(0, 5, 2, IDLE_RECEIVER);
		run_set(100, 3, 2, IDLE_NONE);
		run_set(4, 0, 2, IDLE_SENDER);
		run_set(4, 1500, 2, IDLE_BOTH);
		run_set(127, 2047, 2, IDLE_NONE);
		run_set(1, 200, 4, IDLE_BOTH);

		// back-pressure: results held off while reads keep coming
		run_set(4, 4, 2, IDLE_NONE);
		drain();
		hold_tog <= ~hold_tog;
		repeat (12) offer(read_row(6'($urandom_range(3)), 6'($urandom_range(3))));
		drain();

		base = offered;
		set_no = 0;
		while (offered - base < RANDOM_ITEMS) begin
			sel = $urandom_range(9);
			if (sel == 0) begin
				n = $urandom_range(grm_pkg::MAX_INDIVIDUALS, 9);
				m = $urandom_range(2, 1);
			end else if (sel == 1) begin
				n = $urandom_range(3, 2);
				m = $urandom_range(64, 9);
			end else begin
				n = $urandom_range(8, 1);
				m = $urandom_range(8, 1);
			end
			run_set(n, m, $urandom_range(12, 4), set_no % 4);
			set_no++;
		end

		drain();
		repeat (END_WAIT) @(posedge clk);
		if (faults == 0 && due_entries.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
